// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the magnet debounce block.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// File: hw/rtl/mdda_pkg.sv
// Package for the magnet debounce / double activation block.
// Holds register indexes, reset values, widths, the configuration struct and the flags struct.
package mdda_pkg;

  // Width of the configuration index; indexes past the last register are ignored.
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int TICK_W = 16;
  localparam int DEFAULT_COUNT_WIDTH = 16;

  // Register reset values.
  localparam logic              RST_ACTIVE_LEVEL = 1'b1;
  localparam logic [TICK_W-1:0] RST_DEBOUNCE     = 16'd1000;
  localparam logic [TICK_W-1:0] RST_MIN_INTERVAL = 16'd500;
  localparam logic [TICK_W-1:0] RST_TIMEOUT      = 16'd3000;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LEVEL = 4'd0,
    CFG_DEBOUNCE     = 4'd1,
    CFG_MIN_INTERVAL = 4'd2,
    CFG_TIMEOUT      = 4'd3
  } cfg_index_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic              active_level;
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] min_interval_ticks;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  // Result flags of one tick.
  typedef struct packed {
    logic present;
    logic double_active;
    logic single_active;
  } flags_t;

endpackage

// File: hw/rtl/mdda_cfg_regs.sv
// Configuration register file of the magnet debounce block.
// Depends on mdda_pkg for register indexes, reset values and cfg_t.
module mdda_cfg_regs import mdda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  // Decode the index on each write transfer; unknown indexes leave all registers alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level       <= RST_ACTIVE_LEVEL;
      cfg.debounce_ticks     <= RST_DEBOUNCE;
      cfg.min_interval_ticks <= RST_MIN_INTERVAL;
      cfg.timeout_ticks      <= RST_TIMEOUT;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_ACTIVE_LEVEL: cfg.active_level       <= wr_data[0];
        CFG_DEBOUNCE:     cfg.debounce_ticks     <= wr_data[TICK_W-1:0];
        CFG_MIN_INTERVAL: cfg.min_interval_ticks <= wr_data[TICK_W-1:0];
        CFG_TIMEOUT:      cfg.timeout_ticks      <= wr_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/mdda_core.sv
// Debounce and activation state of the magnet block, updated once per tick.
// Depends on mdda_pkg for cfg_t and flags_t.
module mdda_core import mdda_pkg::*; #(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   pin_level,
  input  cfg_t   cfg,
  output flags_t flags_next
);

  // Compare width covers both the counters and the 16-bit thresholds.
  localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   present, present_next;
  logic                   single_flag, single_next;
  logic                   double_flag, double_next;
  logic [COUNT_WIDTH-1:0] press_count, press_next;
  logic [COUNT_WIDTH-1:0] release_count, release_next;
  logic [COUNT_WIDTH-1:0] since_count, since_next;

  logic                   detected;
  logic [COUNT_WIDTH-1:0] press_inc, release_inc, since_reload;
  logic [CMP_W-1:0]       debounce_ext, min_ext, timeout_ext, since_ext;
  logic                   in_window;

  // Saturating increments, widened thresholds and the clamped timeout reload.
  always_comb begin
    detected     = (pin_level == cfg.active_level);
    press_inc    = (press_count == CNT_MAX) ? CNT_MAX : press_count + 1'b1;
    release_inc  = (release_count == CNT_MAX) ? CNT_MAX : release_count + 1'b1;
    debounce_ext = CMP_W'(cfg.debounce_ticks);
    min_ext      = CMP_W'(cfg.min_interval_ticks);
    timeout_ext  = CMP_W'(cfg.timeout_ticks);
    since_ext    = CMP_W'(since_count);
    in_window    = (since_ext > min_ext) && (since_ext < timeout_ext);
    since_reload = (timeout_ext > CMP_W'(CNT_MAX)) ? CNT_MAX
                                                   : timeout_ext[COUNT_WIDTH-1:0];
  end

  // Next state for one tick.
  always_comb begin
    present_next = present;
    single_next  = single_flag;
    double_next  = double_flag;
    press_next   = press_count;
    release_next = release_count;
    since_next   = since_count;

    if (detected && !present) begin
      // Presses accumulate; a bounce back does not clear the count.
      if (CMP_W'(press_inc) > debounce_ext) begin
        present_next = 1'b1;
        press_next   = '0;
        double_next  = in_window;
        single_next  = !in_window;
        since_next   = '0;
      end else begin
        press_next = press_inc;
      end
    end else if (!detected && present) begin
      if (CMP_W'(release_inc) > debounce_ext) begin
        present_next = 1'b0;
        release_next = '0;
      end else begin
        release_next = release_inc;
      end
    end

    // Ticks since last single activation; at CNT_MAX reloads the timeout clamped to CNT_MAX.
    if (single_next) begin
      since_next = (since_next == CNT_MAX) ? since_reload : since_next + 1'b1;
    end
  end

  // State registers advance on each tick transfer into the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      present       <= 1'b0;
      single_flag   <= 1'b0;
      double_flag   <= 1'b0;
      press_count   <= '0;
      release_count <= '0;
      since_count   <= '0;
    end else if (step) begin
      present       <= present_next;
      single_flag   <= single_next;
      double_flag   <= double_next;
      press_count   <= press_next;
      release_count <= release_next;
      since_count   <= since_next;
    end
  end

  assign flags_next.present       = present_next;
  assign flags_next.double_active = double_next;
  assign flags_next.single_active = single_next;

endmodule

// File: hw/rtl/magnet_debounce_double_activation.sv
// Top level of the magnet debounce / double activation block.
// Depends on mdda_pkg, mdda_cfg_regs, mdda_core and assert_macros.svh.
//
// Usage:
//   Each input transfer on in_valid/in_ready carries one raw pin sample
//   (pin_level), one tick. Each tick yields exactly one result transfer on
//   out_valid/out_ready with the debounced present flag and the double and
//   single activation flags as they stand after that tick.
//   Configuration is written through cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Index 0 is the active pin level,
//   1 the debounce count, 2 the minimum interval and 3 the timeout; other
//   indexes are ignored. Write only while no tick is in flight.
//   An accepted sample is held in the input register; when it moves on, the
//   counter state updates and the result register loads in the same cycle.
//   Throughput: one tick per cycle while the receiver takes results, with
//   the counter update between the input register and the result register.
//   Reset clears all debounce state and loads the default configuration.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are occupied.
`include "assert_macros.svh"

module magnet_debounce_double_activation import mdda_pkg::*; #(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  pin_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  present,
  output logic                  double_active,
  output logic                  single_active,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  flags_t flags_next;
  logic   in_full;
  logic   in_pin;
  logic   step;

  assign cfg_ready = 1'b1;

  mdda_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // A tick moves into the result stage when that stage is empty or being drained.
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pin <= pin_level;
    end
  end

  mdda_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pin_level  (in_pin),
    .cfg        (cfg),
    .flags_next (flags_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      present       <= flags_next.present;
      double_active <= flags_next.double_active;
      single_active <= flags_next.single_active;
    end
  end

  // A press is either single or double, never both.
  `ASSERT_NEVER(a_flags_exclusive, clk, rst, out_valid && double_active && single_active)
  // An empty result stage never holds back the input side.
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  // A buffered tick always reaches an empty result stage at the next edge.
  `ASSERT_NEXT(a_tick_advances, clk, rst, in_full && !out_valid, out_valid)

endmodule

// File: tb/tb_magnet_debounce_double_activation.sv
// Self-checking testbench for magnet_debounce_double_activation: random and directed pin
// samples, register phases, and a per-tick flag predictor checked on every result.
// Depends on mdda_pkg and the block's RTL.
module tb_magnet_debounce_double_activation import mdda_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_PRINTED    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = '1;
  localparam logic [DEFAULT_COUNT_WIDTH-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  pin_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  present;
  logic                  double_active;
  logic                  single_active;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Pending stimulus and outstanding expectations.
  logic       pin_samples[$];
  reg_write_t reg_writes[$];
  flags_t     flags_due[$];

  // Predictor state: register copy and debounce / activation state.
  cfg_t                           regs;
  logic                           sensed;
  logic [DEFAULT_COUNT_WIDTH-1:0] press_run;
  logic [DEFAULT_COUNT_WIDTH-1:0] release_run;
  logic [DEFAULT_COUNT_WIDTH-1:0] since_press;
  logic                           single_seen;
  logic                           double_seen;

  int unsigned cyc = 0;
  bit          steady;
  int          errors = 0;
  int          idle_run = 0;
  int          n_ticks = 0;
  int          n_writes = 0;
  int          n_single = 0;
  int          n_double = 0;

  magnet_debounce_double_activation u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pin_level     (pin_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .present       (present),
    .double_active (double_active),
    .single_active (single_active),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Random idles and stalls are switched off for a stretch at the start of each period of the cycle count.
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end
  assign steady = (cyc % 5000) < 600;

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 34);
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_error($sformatf("%s is %b, expected %b (tick result %0d)", name, got, want,
                             n_ticks - flags_due.size()));
    end
  endtask

  // Register write as the block decodes it; unknown indexes change nothing.
  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ACTIVE_LEVEL: regs.active_level       = data[0];
      CFG_DEBOUNCE:     regs.debounce_ticks     = data;
      CFG_MIN_INTERVAL: regs.min_interval_ticks = data;
      CFG_TIMEOUT:      regs.timeout_ticks      = data;
      default: ;
    endcase
  endtask

  // One tick of the sensor: debounce, classify a new press, then age the
  // since-press counter while a single activation stands.
  task automatic advance_sensor(input logic pin, output flags_t res);
    logic hit;
    hit = (pin == regs.active_level);
    if (hit) begin
      if (!sensed) begin
        if (press_run != COUNT_TOP) press_run = press_run + 1'b1;
        if (press_run > regs.debounce_ticks) begin
          sensed    = 1'b1;
          press_run = '0;
          if (since_press > regs.min_interval_ticks && since_press < regs.timeout_ticks) begin
            double_seen = 1'b1;
            single_seen = 1'b0;
            n_double++;
          end else begin
            double_seen = 1'b0;
            single_seen = 1'b1;
            n_single++;
          end
          since_press = '0;
        end
      end
    end else if (sensed) begin
      if (release_run != COUNT_TOP) release_run = release_run + 1'b1;
      if (release_run > regs.debounce_ticks) begin
        sensed      = 1'b0;
        release_run = '0;
      end
    end
    // At the top the counter reloads with the timeout, so it stays at or past it.
    if (single_seen) begin
      if (since_press == COUNT_TOP) since_press = regs.timeout_ticks;
      else since_press = since_press + 1'b1;
    end
    res = {sensed, double_seen, single_seen};
  endtask

  // Pin sample driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      pin_level <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pin_samples.size() != 0 && !take_break()) begin
        in_valid  <= 1'b1;
        pin_level <= pin_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  // Register write driver.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (reg_writes.size() != 0) begin
        reg_write_t w;
        w = reg_writes.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= w.idx;
        cfg_data  <= w.data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // Monitor: follows every transfer, predicts per tick, checks each result
  // against the oldest expectation, and guards against a hang.
  always @(posedge clk) begin : monitor
    flags_t predicted;
    flags_t got;
    flags_t want;
    bit     moved;
    if (rst) begin
      regs.active_level       = RST_ACTIVE_LEVEL;
      regs.debounce_ticks     = RST_DEBOUNCE;
      regs.min_interval_ticks = RST_MIN_INTERVAL;
      regs.timeout_ticks      = RST_TIMEOUT;
      sensed      = 1'b0;
      press_run   = '0;
      release_run = '0;
      since_press = '0;
      single_seen = 1'b0;
      double_seen = 1'b0;
      flags_due.delete();
      idle_run = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        apply_write(cfg_index, cfg_data);
        n_writes++;
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        advance_sensor(pin_level, predicted);
        flags_due.push_back(predicted);
        n_ticks++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        got   = {present, double_active, single_active};
        moved = 1'b1;
        if (flags_due.size() == 0) begin
          report_error($sformatf("result %b with no tick outstanding", got));
        end else begin
          want = flags_due.pop_front();
          check_flag("present", got.present, want.present);
          check_flag("double_active", got.double_active, want.double_active);
          check_flag("single_active", got.single_active, want.single_active);
        end
      end
      if (moved) begin
        idle_run = 0;
      end else begin
        idle_run++;
        if (idle_run >= WATCHDOG_LIMIT) begin
          $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                   idle_run, flags_due.size());
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Wait until every sample went in and every result came back.
  task automatic drain();
    while (pin_samples.size() != 0 || in_valid || flags_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_writes.push_back({idx, data});
    while (reg_writes.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] act, input logic [CFG_DATA_W-1:0] deb,
                          input logic [CFG_DATA_W-1:0] min_gap,
                          input logic [CFG_DATA_W-1:0] tmo);
    write_reg(CFG_ACTIVE_LEVEL, act);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_MIN_INTERVAL, min_gap);
    write_reg(CFG_TIMEOUT, tmo);
  endtask

  task automatic queue_run(input logic lvl, input int len);
    for (int i = 0; i < len; i++) pin_samples.push_back(lvl);
  endtask

  // Mostly clean press / release pairs held past the debounce count, with
  // random gaps so presses land below, inside and beyond the double window;
  // the rest is short random noise that bounces the pin.
  task automatic queue_presses(input int count);
    int   start;
    int   deb;
    logic act;
    start = pin_samples.size();
    deb   = regs.debounce_ticks;
    act   = regs.active_level;
    while (pin_samples.size() - start < count) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 6)) pin_samples.push_back(1'($urandom));
      end else begin
        queue_run(act, deb + 1 + $urandom_range(0, 3));
        queue_run(!act, deb + 1 + $urandom_range(0, 24));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default registers: a short press stays below the thousand-tick debounce.
    queue_run(1'b1, 20);
    queue_run(1'b0, 3);
    drain();

    // Directed: no debounce, window of more than 2 and under 6 ticks, release gaps of 1 to 6
    // ticks so presses fall below, inside and past the window, and the
    // press right after a double comes out single. The index past the last
    // register must be ignored, and upper data bits of the level dropped.
    set_regs(16'hFFFF, 16'd0, 16'd2, 16'd6);
    write_reg(CFG_IDX_NONE, 16'hFFFF);
    for (int g = 1; g <= 6; g++) begin
      queue_run(1'b0, g);
      queue_run(1'b1, 1);
    end
    drain();

    // Random phases over several register settings, extremes among them.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(16'hFFFE, 16'd0, 16'd1, 16'd8);
        1: set_regs(16'd1, 16'd2, 16'd3, 16'd25);
        2: set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 4)),
                    16'($urandom_range(0, 10)), 16'($urandom_range(5, 40)));
        3: set_regs(16'd1, 16'd1, 16'd0, 16'hFFFF);
        4: set_regs(16'd0, 16'd3, 16'hFFFF, 16'd0);
        default: set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      queue_presses(90);
      drain();
    end

    $display("Run covered %0d pin ticks and %0d register writes.", n_ticks, n_writes);
    $display("Predicted presses: %0d single, %0d double; mismatches: %0d.",
             n_single, n_double, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
